/* rtl/lspi_pkg.sv */
// Shared types and constants for the looping sample player.
// Used by the player top level and its checker; depends on nothing.
package lspi_pkg;

    // Fixed-point layout of the playhead (Q18.16) and related widths
    localparam int POS_W  = 34;
    localparam int FRAC_W = 16;
    localparam int IDX_W  = POS_W - FRAC_W;
    localparam int LEN_W  = 17;
    localparam int SMP_W  = 16;

    // 1.0 in the 16-bit fraction, and the rounding half
    localparam logic [FRAC_W:0] ONE_Q16  = (FRAC_W + 1)'(1) << FRAC_W;
    localparam logic [FRAC_W:0] HALF_Q16 = ONE_Q16 >> 1;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [0:0] REG_CLIP_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] CLIP_LENGTH_RESET = LEN_W'(2);

    // Command codes
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_GEN    = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;

    // Command word
    typedef struct packed {
        logic [1:0]              cmd;
        logic [15:0]             address;
        logic signed [SMP_W-1:0] sample_value;
        logic [23:0]             step;
        logic [6:0]              count;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic signed [SMP_W-1:0] sample_out;
        logic                    last;
    } t_out_word;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_RED,
        ST_WRITE,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_OUT
    } t_state;

endpackage

/* rtl/lspi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module lspi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/looping_sample_player_interp.sv */
// Looping sample player with linear interpolation: clip store, playhead and sequencer.
// Depends on lspi_pkg and lspi_ram.
//
// Commands are taken when start is high and busy is low. A clip write passes
// through ST_WRITE; a playhead reset and an unused command leave busy low.
// A generate command yields count output words (saturated to MAX_RUN), each
// through ST_WRAP, ST_RD_A, ST_RD_B, ST_MUL and ST_OUT: one state applies the
// loop wrap, the clip store has one read port, so the two neighboring samples
// are fetched one after the other, then the single multiplier forms the blend
// and a last state rounds and advances the playhead.
// When a store index (write address or playhead index) lies at or beyond
// CLIP_DEPTH, a shift-subtract reducer (ST_RED) brings it into range first.
// Each output word is shown on o_res for one cycle with o_strobe high and
// cannot be held off. The store needs no clearing pass: reads of
// never-written entries are undefined.
module looping_sample_player_interp #(
    parameter int CLIP_DEPTH = 65536,
    parameter int MAX_RUN    = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command side
    input  logic                        start,
    output logic                        busy,
    input  lspi_pkg::t_in_word          i_req,
    // result side
    output logic                        o_strobe,
    output lspi_pkg::t_out_word         o_res,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lspi_pkg::CFG_AW-1:0] paddr,
    input  logic [lspi_pkg::CFG_DW-1:0] pwdata,
    output logic [lspi_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);

    import lspi_pkg::*;

    localparam int AW    = $clog2(CLIP_DEPTH);
    localparam int MW    = ((AW > IDX_W) ? AW : IDX_W) + 2;
    localparam int K_TOP = (AW >= IDX_W) ? 0 : IDX_W - AW;
    localparam int RW    = $clog2(MAX_RUN + 1);
    localparam logic [MW-1:0] DEPTH_M  = MW'(CLIP_DEPTH);
    localparam logic [MW-1:0] DSH_TOP  = DEPTH_M << K_TOP;
    localparam logic [AW:0]   DEPTH_A  = (AW + 1)'(CLIP_DEPTH);
    localparam logic [6:0]    RUN_MAX  = 7'(MAX_RUN);
    localparam logic [RW-1:0] LEFT_ONE = RW'(1);

    t_state r_state, n_state;

    logic [LEN_W-1:0]        r_len;
    logic [POS_W-1:0]        r_pos;
    logic [23:0]             r_step;
    logic [RW-1:0]           r_left;
    logic [MW-1:0]           r_mod;
    logic [MW-1:0]           r_dsh;
    logic                    r_red_wr;
    logic                    r_last_idx;
    logic [AW-1:0]           r_rb;
    logic signed [SMP_W-1:0] r_wdata;
    logic signed [SMP_W-1:0] r_a;
    logic signed [POS_W-1:0] r_prod;
    logic                    r_strobe;
    t_out_word               r_res;

    logic                    accept;
    logic                    cfg_wr;
    logic [LEN_W-1:0]        lm1;
    logic [POS_W-1:0]        lm1_q;
    logic [POS_W-1:0]        pos_wrap;
    logic [IDX_W-1:0]        idx;
    logic                    idx_is_last;
    logic [MW-1:0]           idx_m;
    logic [MW-1:0]           addr_m;
    logic                    idx_small;
    logic                    addr_small;
    logic                    red_ge;
    logic [MW-1:0]           red_val;
    logic                    red_done;
    logic [AW:0]             ra_inc;
    logic [AW-1:0]           rb_next;
    logic [6:0]              run_len;
    logic signed [SMP_W-1:0] rdata;
    logic signed [SMP_W:0]   diff;
    logic signed [FRAC_W:0]  frac_s;
    logic signed [POS_W:0]   acc;
    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CLIP_LENGTH_RESET;
        end else if (cfg_wr && paddr[2] == REG_CLIP_LENGTH) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLIP_LENGTH) ? CFG_DW'(r_len) : '0;

    // Playhead wrap: subtract length-1 once when past the last index
    assign lm1         = (r_len == '0) ? '0 : r_len - LEN_W'(1);
    assign lm1_q       = {1'b0, lm1, {FRAC_W{1'b0}}};
    assign pos_wrap    = (r_pos > lm1_q) ? r_pos - lm1_q : r_pos;
    assign idx         = pos_wrap[POS_W-1:FRAC_W];
    assign idx_is_last = (idx == {1'b0, lm1});
    assign idx_m       = {{(MW-IDX_W){1'b0}}, idx};
    assign addr_m      = {{(MW-16){1'b0}}, i_req.address};
    assign idx_small   = (idx_m < DEPTH_M);
    assign addr_small  = (addr_m < DEPTH_M);

    // Shared reducer: one compare-subtract of a shifted depth per cycle
    assign red_ge   = (r_mod >= r_dsh);
    assign red_val  = red_ge ? r_mod - r_dsh : r_mod;
    assign red_done = (r_dsh == DEPTH_M);

    // Neighbor index, wrapping at the clip end and at the store depth
    assign ra_inc  = {1'b0, r_mod[AW-1:0]} + (AW + 1)'(1);
    assign rb_next = (r_last_idx || ra_inc == DEPTH_A) ? '0 : ra_inc[AW-1:0];

    assign run_len = (i_req.count > RUN_MAX) ? RUN_MAX : i_req.count;

    // Blend arithmetic: a*1.0 + f*(b-a), rounded half up
    assign diff   = {rdata[SMP_W-1], rdata} - {r_a[SMP_W-1], r_a};
    assign frac_s = {1'b0, r_pos[FRAC_W-1:0]};
    assign acc    = {{(POS_W-SMP_W-FRAC_W+1){r_a[SMP_W-1]}}, r_a, {FRAC_W{1'b0}}}
                  + {r_prod[POS_W-1], r_prod}
                  + (POS_W + 1)'(HALF_Q16);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.cmd == CMD_WRITE) begin
                        n_state = addr_small ? ST_WRITE : ST_RED;
                    end else if (i_req.cmd == CMD_GEN && run_len != '0) begin
                        n_state = ST_WRAP;
                    end
                end
            end
            ST_WRAP:  n_state = idx_small ? ST_RD_A : ST_RED;
            ST_RED: begin
                if (red_done) begin
                    n_state = r_red_wr ? ST_WRITE : ST_RD_A;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_RD_A:  n_state = ST_RD_B;
            ST_RD_B:  n_state = ST_MUL;
            ST_MUL:   n_state = ST_OUT;
            ST_OUT:   n_state = (r_left == LEFT_ONE) ? ST_IDLE : ST_WRAP;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        busy      = (r_state != ST_IDLE);
        ram_we    = (r_state == ST_WRITE);
        ram_raddr = (r_state == ST_RD_A) ? r_mod[AW-1:0] : r_rb;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_OUT);
            if (r_state == ST_IDLE && accept && i_req.cmd == CMD_RESET) begin
                r_pos <= '0;
            end else if (r_state == ST_WRAP) begin
                r_pos <= pos_wrap;
            end else if (r_state == ST_OUT) begin
                r_pos <= r_pos + POS_W'(r_step);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_step   <= i_req.step;
                r_left   <= run_len[RW-1:0];
                r_wdata  <= i_req.sample_value;
                r_mod    <= addr_m;
                r_dsh    <= DSH_TOP;
                r_red_wr <= (i_req.cmd == CMD_WRITE);
            end
            ST_WRAP: begin
                r_mod      <= idx_m;
                r_dsh      <= DSH_TOP;
                r_last_idx <= idx_is_last;
            end
            ST_RED: begin
                r_mod <= red_val;
                r_dsh <= r_dsh >> 1;
            end
            ST_RD_A: r_rb <= rb_next;
            ST_RD_B: r_a <= rdata;
            ST_MUL:  r_prod <= POS_W'(frac_s * diff);
            ST_OUT: begin
                r_res.sample_out <= acc[FRAC_W+SMP_W-1:FRAC_W];
                r_res.last       <= (r_left == LEFT_ONE);
                r_left           <= r_left - LEFT_ONE;
            end
            default: ;
        endcase
    end

    // Clip store
    lspi_ram #(
        .WIDTH (SMP_W),
        .DEPTH (CLIP_DEPTH)
    ) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_mod[AW-1:0]),
        .i_wdata (r_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

/* rtl/lspi_chk.sv */
// Port-level checks for the looping sample player, bound to the top level.
// Depends on lspi_pkg.
module lspi_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input lspi_pkg::t_in_word          i_req,
    input logic                        o_strobe,
    input lspi_pkg::t_out_word         o_res
);

    import lspi_pkg::*;

    // Output words are spaced by the sequencer, never adjacent
    a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two output words in adjacent cycles");

    // A word that is not the last of a run leaves the block running
    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |-> busy)
        else $error("run ended without a last word");

    // The last word of a run appears once the block is free again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |-> !busy)
        else $error("block still busy at last word");

    // A clip write always holds the block for its store cycle
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.cmd == CMD_WRITE |=> busy)
        else $error("clip write did not occupy the block");

    // No output word without a generate run having been taken
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && !$past(busy) |-> !o_strobe)
        else $error("output word while idle");

endmodule

bind looping_sample_player_interp lspi_chk u_lspi_chk (.*);
